### rtl/cesc_pkg.sv
// Shared types, codes and helpers for the C escape decoder.
package cesc_pkg;

  // Result status codes
  localparam logic [1:0] ST_BYTE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Output queue depth and pointer width
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Parser mode, one-hot
  typedef enum logic [6:0] {
    MODE_PLAIN    = 7'b000_0001,
    MODE_ESC      = 7'b000_0010,
    MODE_OCT      = 7'b000_0100,
    MODE_DEC      = 7'b000_1000,
    MODE_HEXSTART = 7'b001_0000,
    MODE_HEX      = 7'b010_0000,
    MODE_ERROR    = 7'b100_0000
  } mode_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } res_t;

  // Results produced by one decode step
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Hex digit value of a byte; 16 when it is no hex digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h37);
    return d;
  endfunction

endpackage

### rtl/cesc_decode.sv
// Decode step: parser mode and run accumulator, up to two results per byte.
module cesc_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [7:0]     ch,
  input  logic           is_end,
  output cesc_pkg::push_t push
);
  import cesc_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [7:0] accum_r, accum_nxt;

  logic [4:0] d;
  logic       run_mode, in_radix, flushed;
  mode_t      m2;
  logic       has_t;
  res_t       tr, fr;

  assign d = digit_of(ch);

  // Numeric run: accumulate or flush
  always_comb begin
    run_mode = 1'b0;
    in_radix = 1'b0;
    case (mode_r)
      MODE_OCT: begin
        run_mode = 1'b1;
        in_radix = d < 5'd8;
      end
      MODE_DEC: begin
        run_mode = 1'b1;
        in_radix = d < 5'd10;
      end
      MODE_HEX: begin
        run_mode = 1'b1;
        in_radix = d < 5'd16;
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    accum_nxt = accum_r;
    flushed = 1'b0;
    has_t = 1'b0;
    tr = '0;
    fr = '0;
    m2 = mode_r;
    push = '0;

    if (run_mode && !is_end && in_radix) begin
      // digit extends the run
      case (mode_r)
        MODE_OCT: accum_nxt = {accum_r[4:0], 3'b000} + {5'd0, d[2:0]};
        MODE_DEC: accum_nxt = {accum_r[4:0], 3'b000} + {accum_r[6:0], 1'b0}
                              + {4'd0, d[3:0]};
        default:  accum_nxt = {accum_r[3:0], 4'b0000} + {4'd0, d[3:0]};
      endcase
    end else begin
      if (run_mode) begin
        flushed = 1'b1;
        fr.data = accum_r;
        fr.status = ST_BYTE;
        m2 = MODE_PLAIN;
      end

      // Handle the byte in the (possibly flushed) mode
      case (m2)
        MODE_HEXSTART: begin
          if (!is_end && d < 5'd16) begin
            accum_nxt = {4'd0, d[3:0]};
            mode_nxt = MODE_HEX;
          end else begin
            mode_nxt = is_end ? MODE_PLAIN : MODE_ERROR;
            has_t = 1'b1;
            tr.status = ST_ERR;
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_PLAIN;
          if (is_end) begin
            has_t = 1'b1;
            tr.status = ST_ERR;
          end else begin
            has_t = 1'b1;
            tr.status = ST_BYTE;
            case (ch)
              8'h61: tr.data = 8'h07;  // a
              8'h62: tr.data = 8'h08;  // b
              8'h66: tr.data = 8'h0C;  // f
              8'h6E: tr.data = 8'h0A;  // n
              8'h72: tr.data = 8'h0D;  // r
              8'h74: tr.data = 8'h09;  // t
              8'h76: tr.data = 8'h0B;  // v
              8'h5C, 8'h27, 8'h22, 8'h3F: tr.data = ch;  // quoted chars
              8'h78, 8'h58: begin  // x, X
                has_t = 1'b0;
                mode_nxt = MODE_HEXSTART;
              end
              8'h30: begin  // octal run
                has_t = 1'b0;
                accum_nxt = 8'd0;
                mode_nxt = MODE_OCT;
              end
              default: begin
                if (ch inside {[8'h31:8'h39]}) begin  // decimal run
                  has_t = 1'b0;
                  accum_nxt = {4'd0, d[3:0]};
                  mode_nxt = MODE_DEC;
                end else begin
                  mode_nxt = MODE_ERROR;
                  tr.status = ST_ERR;
                end
              end
            endcase
          end
        end
        MODE_ERROR: begin
          if (is_end) mode_nxt = MODE_PLAIN;
        end
        default: begin
          mode_nxt = MODE_PLAIN;
          if (is_end) begin
            accum_nxt = 8'd0;
            has_t = 1'b1;
            tr.status = ST_DONE;
          end else if (ch == 8'h5C) begin  // backslash
            mode_nxt = MODE_ESC;
          end else if (ch != 8'h22) begin  // bare quote dropped
            has_t = 1'b1;
            tr.data = ch;
            tr.status = ST_BYTE;
          end
        end
      endcase

      // Pack results in order, last flag on the final one
      if (flushed) begin
        push.r0 = fr;
        push.r1 = tr;
        push.cnt = has_t ? 2'd2 : 2'd1;
        if (has_t) push.r1.last = 1'b1;
        else push.r0.last = 1'b1;
      end else begin
        push.r0 = tr;
        push.r0.last = 1'b1;
        push.cnt = has_t ? 2'd1 : 2'd0;
      end
    end

    if (!go) push.cnt = 2'd0;
  end

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      accum_r <= 8'd0;
    end else if (go) begin
      mode_r <= mode_nxt;
      accum_r <= accum_nxt;
    end
  end

endmodule

### rtl/cesc_outq.sv
// Result queue: takes up to two results a cycle, delivers one per transfer.
module cesc_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  cesc_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output cesc_pkg::res_t  out_res
);
  import cesc_pkg::*;

  res_t             q_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic             pop;
  logic [QPtrW-1:0] wr_ptr_p1;

  // Room for a full two-result push
  assign room = count_r <= QCntW'(QDepth - 2);
  assign out_valid = count_r != '0;
  assign out_res = q_r[rd_ptr_r];
  assign pop = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r + QCntW'(push.cnt) - QCntW'(pop);
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) q_r[wr_ptr_p1] <= push.r1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/c_escape_decoder.sv
// Top level of the streaming C escape decoder.
// Takes one source byte per cycle and returns decoded bytes, one end-of-string
// status per string (status 1 ok, 2 parse error) and last on the final result
// of each input byte. An accepted byte waits in the input register until
// the queue has room, is decoded against the mode and run value in a single
// pass, and its results enter a four-entry output queue, which offers the
// oldest result on the output; it transfers when out_stall is low.
// A byte yields zero, one or two results; a byte that yields two occupies the
// output for two transfers, so one byte per cycle is sustained while results
// average at most one per byte and out_stall is low. The input stalls while a
// byte waits in the input register and the queue has under two free entries.
module c_escape_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_is_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_last
);
  import cesc_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_end_r;
  logic       room, go;
  push_t      push;
  res_t       out_res;

  assign go = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ch_r <= in_ch;
      s1_end_r <= in_is_end;
    end
  end

  cesc_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .ch     (s1_ch_r),
    .is_end (s1_end_r),
    .push   (push)
  );

  cesc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte = out_res.data;
  assign out_status = out_res.status;
  assign out_last = out_res.last;

endmodule

### rtl/cesc_checker.sv
// Port-level checks for the C escape decoder, bound to the top level.
module cesc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] out_status,
  input logic       out_last
);
  import cesc_pkg::*;

  // Nothing pending and input open right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result withdrawn");

  // String status always closes the results of its input byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DONE || out_status == ST_ERR) |-> out_last)
    else $error("status result without last");

  // Status results carry a zero byte, and no unused status code appears
  a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_BYTE |-> out_byte == 8'd0 && out_status != 2'd3)
    else $error("bad status result payload");

endmodule

bind c_escape_decoder cesc_checker u_cesc_checker (.*);

### verif/c_escape_decoder_tb.sv
// Self-checking testbench for the C escape decoder: directed table, then random strings.
`timescale 1ns / 100ps

module c_escape_decoder_tb;
  import cesc_pkg::*;

  localparam int          RAND_ITEMS = 1000;
  localparam int          SETTLE_CYC = 8;
  localparam int          DRAIN_MAX  = 5000;
  localparam int          HOLD_CYC   = 120;
  localparam longint      LIMIT_NS   = 2_000_000;

  localparam logic [7:0]  BSL    = 8'h5C;
  localparam logic [7:0]  QUOTE  = 8'h22;
  localparam logic [7:0]  SQUOTE = 8'h27;
  localparam logic [7:0]  QMARK  = 8'h3F;

  localparam string       NAMED  = "abfnrtv\\'\"?";
  localparam string       HEXDIG = "0123456789abcdefABCDEF";

  localparam res_t        R_NONE = '0;
  localparam push_t       NO_RES = '0;

  // One directed row; want is used only where typed is set
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
    logic       typed;
    push_t      want;
  } row_t;

  localparam int DIR_N = 27;
  localparam row_t DIR_ROWS [DIR_N] = '{
    // byte extremes, then a bare quote that is dropped
    '{8'h00, 1'b0, 1'b1, '{2'd1, '{8'h00, ST_BYTE, 1'b1}, R_NONE}},
    '{8'hFF, 1'b0, 1'b1, '{2'd1, '{8'hFF, ST_BYTE, 1'b1}, R_NONE}},
    '{QUOTE, 1'b0, 1'b1, NO_RES},
    // unknown escape; error mode swallows the rest and the end
    '{BSL,   1'b0, 1'b1, NO_RES},
    '{"q",   1'b0, 1'b1, '{2'd1, '{8'h00, ST_ERR, 1'b1}, R_NONE}},
    '{"z",   1'b0, 1'b1, NO_RES},
    '{8'hA5, 1'b1, 1'b1, NO_RES},
    // empty string
    '{8'h00, 1'b1, 1'b1, '{2'd1, '{8'h00, ST_DONE, 1'b1}, R_NONE}},
    // named escape
    '{BSL,   1'b0, 1'b1, NO_RES},
    '{"t",   1'b0, 1'b0, NO_RES},
    // octal run that wraps, closed by the string end
    '{BSL,   1'b0, 1'b1, NO_RES},
    '{"0",   1'b0, 1'b1, NO_RES},
    '{"7",   1'b0, 1'b0, NO_RES},
    '{"7",   1'b0, 1'b0, NO_RES},
    '{"7",   1'b0, 1'b0, NO_RES},
    '{8'h3C, 1'b1, 1'b0, NO_RES},
    // hex run with both digit cases, ended by a non-digit
    '{BSL,   1'b0, 1'b1, NO_RES},
    '{"X",   1'b0, 1'b0, NO_RES},
    '{"f",   1'b0, 1'b0, NO_RES},
    '{"F",   1'b0, 1'b0, NO_RES},
    '{"G",   1'b0, 1'b0, NO_RES},
    // bad hex start
    '{BSL,   1'b0, 1'b1, NO_RES},
    '{"x",   1'b0, 1'b0, NO_RES},
    '{"g",   1'b0, 1'b1, '{2'd1, '{8'h00, ST_ERR, 1'b1}, R_NONE}},
    '{BSL,   1'b1, 1'b1, NO_RES},
    // trailing backslash
    '{BSL,   1'b0, 1'b1, NO_RES},
    '{8'hFF, 1'b1, 1'b1, '{2'd1, '{8'h00, ST_ERR, 1'b1}, R_NONE}}
  };

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_style_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_ch     = 8'h00;
  logic       in_is_end = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_last;

  // decoder state mirrored by the predictor
  mode_t      dec_mode = MODE_PLAIN;
  logic [7:0] run_val  = 8'h00;

  res_t       byte_q [$];
  logic [8:0] str_q [$];
  push_t      step_res;
  logic       row_typed = 1'b0;
  push_t      row_want  = '0;
  int         err_cnt   = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  logic       hold_req  = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  int         rx_cyc    = 0;
  rx_style_t  rx_style  = RX_FREE;

  c_escape_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .in_is_end  (in_is_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int unsigned hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic push_t add_res(input push_t p, input logic [7:0] b, input logic [1:0] st);
    if (p.cnt == 2'd0) p.r0 = '{b, st, 1'b0};
    else p.r1 = '{b, st, 1'b0};
    p.cnt = p.cnt + 2'd1;
    return p;
  endfunction

  // Decoded bytes and status caused by one source item; updates mode and run value
  function automatic push_t decode_step(input logic [7:0] c, input logic e);
    push_t       p;
    int unsigned d;
    int unsigned radix;
    p = '0;
    d = hex_val(c);
    // numeric run: absorb a digit, or flush the value and fall through as plain
    if (dec_mode inside {MODE_OCT, MODE_DEC, MODE_HEX}) begin
      radix = (dec_mode == MODE_OCT) ? 8 : (dec_mode == MODE_DEC) ? 10 : 16;
      if (!e && d < radix) begin
        run_val = 8'(run_val * radix + d);
        return p;
      end
      p = add_res(p, run_val, ST_BYTE);
      dec_mode = MODE_PLAIN;
    end
    case (dec_mode)
      MODE_HEXSTART: begin
        if (!e && d < 16) begin
          run_val = 8'(d);
          dec_mode = MODE_HEX;
          return p;
        end
        dec_mode = e ? MODE_PLAIN : MODE_ERROR;
        p = add_res(p, 8'h00, ST_ERR);
      end
      MODE_ESC: begin
        if (e) begin
          dec_mode = MODE_PLAIN;
          p = add_res(p, 8'h00, ST_ERR);
        end else begin
          dec_mode = MODE_PLAIN;
          case (c)
            "a": p = add_res(p, 8'h07, ST_BYTE);
            "b": p = add_res(p, 8'h08, ST_BYTE);
            "f": p = add_res(p, 8'h0C, ST_BYTE);
            "n": p = add_res(p, 8'h0A, ST_BYTE);
            "r": p = add_res(p, 8'h0D, ST_BYTE);
            "t": p = add_res(p, 8'h09, ST_BYTE);
            "v": p = add_res(p, 8'h0B, ST_BYTE);
            BSL, SQUOTE, QUOTE, QMARK: p = add_res(p, c, ST_BYTE);
            "x", "X": dec_mode = MODE_HEXSTART;
            "0": begin
              run_val = 8'h00;
              dec_mode = MODE_OCT;
            end
            "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
              run_val = 8'(d);
              dec_mode = MODE_DEC;
            end
            default: begin
              dec_mode = MODE_ERROR;
              p = add_res(p, 8'h00, ST_ERR);
            end
          endcase
        end
      end
      MODE_ERROR: begin
        if (e) dec_mode = MODE_PLAIN;
      end
      default: begin
        dec_mode = MODE_PLAIN;
        if (e) begin
          run_val = 8'h00;
          p = add_res(p, 8'h00, ST_DONE);
        end else if (c == BSL) begin
          dec_mode = MODE_ESC;
        end else if (c != QUOTE) begin
          p = add_res(p, c, ST_BYTE);
        end
      end
    endcase
    if (p.cnt == 2'd2) p.r1.last = 1'b1;
    else if (p.cnt == 2'd1) p.r0.last = 1'b1;
    return p;
  endfunction

  // Predict on every input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      dec_mode = MODE_PLAIN;
      run_val  = 8'h00;
    end else if (in_valid && !in_stall) begin
      step_res = decode_step(in_ch, in_is_end);
      if (row_typed) step_res = row_want;
      if (step_res.cnt > 0) byte_q.push_back(step_res.r0);
      if (step_res.cnt > 1) byte_q.push_back(step_res.r1);
    end
  end

  // Check every output transfer against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (byte_q.size() == 0) begin
        report_err($sformatf("unexpected result byte=%02h status=%0d last=%0d",
                             out_byte, out_status, out_last));
      end else begin
        want = byte_q.pop_front();
        if (out_byte !== want.data)
          report_err($sformatf("byte %02h, want %02h", out_byte, want.data));
        if (out_status !== want.status)
          report_err($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_last !== want.last)
          report_err($sformatf("last %0d, want %0d", out_last, want.last));
      end
    end
  end

  // Receiver: stalls in a randomly redrawn style; a hold request stalls a long stretch
  always @(negedge clk) begin
    rx_cyc++;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYC;
    end
    if (rx_cyc % 256 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_style)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ((rx_cyc % 7) < 3);
      endcase
    end
  end

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      in_ch     <= 8'($urandom);
      in_is_end <= 1'($urandom);
    end
  endtask

  // Sender bursts with random gaps in between
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic send_item(input logic [7:0] c, input logic e, input logic typed,
                           input push_t want);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_ch     <= c;
    in_is_end <= e;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // Sender stays idle until every expected result is back or the wait limit runs out, then settles
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (byte_q.size() != 0 && waited < DRAIN_MAX) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic void put_byte(input logic [7:0] c);
    str_q.push_back({1'b0, c});
  endfunction

  function automatic logic is_esc_start(input logic [7:0] c);
    return (c inside {"a", "b", "f", "n", "r", "t", "v", BSL, SQUOTE, QUOTE, QMARK, "x", "X"})
           || (c >= "0" && c <= "9");
  endfunction

  // One source string: mostly well-formed escapes, some broken ones and raw noise
  task automatic build_string();
    int unsigned kind;
    int unsigned tail;
    logic [7:0]  c;
    str_q.delete();
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        put_byte(QUOTE);
      end else if (kind < 30) begin
        c = 8'($urandom_range(0, 255));
        put_byte(c == BSL ? "A" : c);
      end else if (kind < 45) begin
        put_byte(BSL);
        put_byte(NAMED[$urandom_range(0, 10)]);
      end else if (kind < 80) begin
        put_byte(BSL);
        case ($urandom_range(0, 2))
          0: begin
            put_byte("0");
            repeat ($urandom_range(0, 4)) put_byte(8'("0" + $urandom_range(0, 7)));
          end
          1: begin
            put_byte(8'("1" + $urandom_range(0, 8)));
            repeat ($urandom_range(0, 3)) put_byte(8'("0" + $urandom_range(0, 9)));
          end
          default: begin
            put_byte($urandom_range(0, 1) ? "x" : "X");
            repeat ($urandom_range(1, 4)) put_byte(HEXDIG[$urandom_range(0, 21)]);
          end
        endcase
        // end the run on a digit that is outside a narrow radix
        if ($urandom_range(0, 3) == 0) put_byte(HEXDIG[$urandom_range(8, 21)]);
      end else if (kind < 88) begin
        do c = 8'($urandom_range(0, 255)); while (is_esc_start(c));
        put_byte(BSL);
        put_byte(c);
      end else if (kind < 94) begin
        do c = 8'($urandom_range(0, 255)); while (hex_val(c) < 16);
        put_byte(BSL);
        put_byte("x");
        put_byte(c);
      end else begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
      end
    end
    // trailing backslash or bare x before the end; rarely no end at all
    tail = $urandom_range(0, 99);
    if (tail < 5) begin
      put_byte(BSL);
    end else if (tail < 8) begin
      put_byte(BSL);
      put_byte($urandom_range(0, 1) ? "x" : "X");
    end
    if (tail < 96) str_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [8:0] it;
    bit         held_a;
    bit         held_b;
    bit         paused;
    held_a = 0;
    held_b = 0;
    paused = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      pace();
      send_item(DIR_ROWS[i].ch, DIR_ROWS[i].is_end, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
    drain();

    // random strings
    while (items_sent < DIR_N + RAND_ITEMS) begin
      build_string();
      while (str_q.size() != 0) begin
        it = str_q.pop_front();
        pace();
        send_item(it[7:0], it[8], 1'b0, NO_RES);
      end
      if (!held_a && items_sent >= DIR_N + 250) begin
        held_a = 1;
        hold_req = ~hold_req;
      end
      if (!paused && items_sent >= DIR_N + 500) begin
        paused = 1;
        drain();
      end
      if (!held_b && items_sent >= DIR_N + 750) begin
        held_b = 1;
        hold_req = ~hold_req;
      end
    end
    drain();

    if (byte_q.size() != 0)
      report_err($sformatf("%0d expected results never arrived", byte_q.size()));
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
